// ----- rtl/ltpt_pkg.sv -----
// Shared types and constants for the looping tween progress timer.
package ltpt_pkg;

	localparam int DUR_W          = 32;
	localparam int MODE_W         = 2;
	localparam int NOW_W          = 32;
	localparam int PROG_W         = 17;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 32;
	localparam int TIME_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE = 1'b1;

	localparam logic [MODE_W-1:0] MODE_ONCE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOOP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BOUNCE = 2'd2;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_REWIND = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ELAPSED,
		ST_CHECK,
		ST_OVER,
		ST_MIRROR,
		ST_PREMOD,
		ST_MOD,
		ST_FOLD,
		ST_RESTART,
		ST_FRAC_INIT,
		ST_FRAC,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RK_PLAIN,
		RK_FINISHED,
		RK_PROGRESS
	} res_kind_t;

endpackage

// ----- rtl/ltpt_item_if.sv -----
// Input channel: tick or rewind beats with a time stamp.
interface ltpt_item_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [ltpt_pkg::NOW_W-1:0] now;

	modport source (output valid, output op, output now, input ready);
	modport sink   (input valid, input op, input now, output ready);
endinterface

// ----- rtl/ltpt_result_if.sv -----
// Output channel: running flag and progress beats.
interface ltpt_result_if;
	logic                        valid;
	logic                        ready;
	logic                        running;
	logic                        progress_valid;
	logic [ltpt_pkg::PROG_W-1:0] progress;

	modport source (output valid, output running, output progress_valid, output progress,
		input ready);
	modport sink   (input valid, input running, input progress_valid, input progress,
		output ready);
endinterface

// ----- rtl/ltpt_cfg_if.sv -----
// Configuration write channel: register index and data beats.
interface ltpt_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ltpt_pkg::CFG_IDX_W-1:0]  index;
	logic [ltpt_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/looping_tween_progress_timer.sv -----
// Looping tween progress timer: sequencer around one shared subtractor.
// Rewind or first tick goes straight to the result; run once past its duration reports finished;
// progress divides elapsed by duration; bounce within 2x mirrors first, loop and bounce past 2x take a modulo.
// One item at a time: a new item is taken only when idle; result stall holds all.
// Reset clears start stamp, sequencer and output valid; duration 1, mode run once.
module looping_tween_progress_timer #(
	parameter int TIME_WIDTH = ltpt_pkg::TIME_WIDTH_DEF,
	parameter int FRAC_BITS  = ltpt_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ltpt_item_if.sink     item,
	ltpt_result_if.source result,
	ltpt_cfg_if.sink      cfg
);
	import ltpt_pkg::*;

	localparam int XW        = (TIME_WIDTH > DUR_W ? TIME_WIDTH : DUR_W) + 1;
	localparam int QW        = FRAC_BITS + 1;
	localparam int STEPS_MAX = TIME_WIDTH > QW ? TIME_WIDTH : QW;
	localparam int CNT_W     = $clog2(STEPS_MAX + 1);

	state_t state_q, state_d;
	res_kind_t kind_q, kind_d;

	logic [DUR_W-1:0]      duration_q;
	logic [MODE_W-1:0]     mode_q;
	logic [TIME_WIDTH-1:0] now_q, now_d;
	logic [TIME_WIDTH-1:0] start_q, start_d;
	logic [DUR_W-1:0]      d_q, d_d, d_eff;
	logic [XW-1:0]         e_q, e_d;
	logic [XW-1:0]         r_q, r_d;
	logic [QW-1:0]         q_q, q_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;

	logic              out_valid_q;
	logic              out_running_q;
	logic              out_pvalid_q;
	logic [PROG_W-1:0] out_prog_q;

	logic [XW-1:0] alu_a, alu_b, d_ext;
	logic [XW:0]   diff;
	logic          borrow, dzero, gt;
	logic          item_fire, cfg_fire, out_free, load_out, frac_first;

	assign item.ready   = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign item_fire    = item.valid && item.ready;
	assign cfg_fire     = cfg.valid && cfg.ready;
	assign out_free     = !out_valid_q || result.ready;
	assign d_eff        = (duration_q == '0) ? DUR_W'(1) : duration_q;
	assign d_ext        = XW'(d_q);
	assign frac_first   = (cnt_q == CNT_W'(QW));

	// Shared subtract and compare unit
	assign diff   = {1'b0, alu_a} - {1'b0, alu_b};
	assign borrow = diff[XW];
	assign dzero  = (diff[XW-1:0] == '0);
	assign gt     = !borrow && !dzero;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_fire) begin
					if (item.op == OP_REWIND || start_q == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_ELAPSED;
					end
				end
			end
			ST_ELAPSED: state_d = ST_CHECK;
			ST_CHECK: begin
				if (!gt) begin
					state_d = ST_FRAC_INIT;
				end else begin
					case (mode_q)
						MODE_LOOP:   state_d = ST_PREMOD;
						MODE_BOUNCE: state_d = ST_OVER;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_OVER:      state_d = gt ? ST_PREMOD : ST_MIRROR;
			ST_MIRROR:    state_d = ST_FRAC_INIT;
			ST_PREMOD:    state_d = ST_MOD;
			ST_MOD: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD:      state_d = ST_RESTART;
			ST_RESTART:   state_d = ST_FRAC_INIT;
			ST_FRAC_INIT: state_d = ST_FRAC;
			ST_FRAC: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		alu_a    = e_q;
		alu_b    = d_ext;
		now_d    = now_q;
		start_d  = start_q;
		d_d      = d_q;
		e_d      = e_q;
		r_d      = r_q;
		q_d      = q_q;
		cnt_d    = cnt_q;
		kind_d   = kind_q;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_fire) begin
					now_d  = TIME_WIDTH'(item.now);
					d_d    = d_eff;
					kind_d = RK_PLAIN;
					if (item.op == OP_REWIND) begin
						start_d = '0;
					end else if (start_q == '0) begin
						start_d = TIME_WIDTH'(item.now);
					end
				end
			end
			ST_ELAPSED: begin
				alu_a = XW'(now_q);
				alu_b = XW'(start_q);
				e_d   = XW'(diff[TIME_WIDTH-1:0]);
			end
			ST_CHECK: begin
				if (gt) begin
					case (mode_q)
						MODE_LOOP:   e_d = e_q;
						MODE_BOUNCE: e_d = diff[XW-1:0];
						default:     kind_d = RK_FINISHED;
					endcase
				end
			end
			ST_OVER: begin
				if (gt) begin
					e_d = diff[XW-1:0];
				end
			end
			ST_MIRROR: begin
				alu_a = d_ext;
				alu_b = e_q;
				e_d   = diff[XW-1:0];
			end
			ST_PREMOD: begin
				alu_b = XW'(1);
				e_d   = diff[XW-1:0];
				r_d   = '0;
				cnt_d = CNT_W'(TIME_WIDTH);
			end
			ST_MOD: begin
				alu_a = {r_q[XW-2:0], e_q[TIME_WIDTH-1]};
				r_d   = borrow ? alu_a : diff[XW-1:0];
				e_d   = {e_q[XW-2:0], 1'b0};
				cnt_d = cnt_q - CNT_W'(1);
			end
			ST_FOLD: begin
				alu_a = r_q;
				alu_b = '1;
				e_d   = diff[XW-1:0];
			end
			ST_RESTART: begin
				alu_a   = XW'(now_q);
				alu_b   = e_q;
				start_d = diff[TIME_WIDTH-1:0];
			end
			ST_FRAC_INIT: begin
				r_d   = e_q;
				q_d   = '0;
				cnt_d = CNT_W'(QW);
			end
			ST_FRAC: begin
				alu_a = frac_first ? r_q : {r_q[XW-2:0], 1'b0};
				r_d   = borrow ? alu_a : diff[XW-1:0];
				q_d   = {q_q[QW-2:0], !borrow};
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					kind_d = RK_PROGRESS;
				end
			end
			ST_DONE: load_out = out_free;
			default: load_out = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= RK_PLAIN;
			start_q     <= '0;
			cnt_q       <= '0;
			duration_q  <= DUR_W'(1);
			mode_q      <= MODE_ONCE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			start_q <= start_d;
			cnt_q   <= cnt_d;
			if (cfg_fire) begin
				case (cfg.index)
					REG_DURATION:  duration_q <= cfg.data[DUR_W-1:0];
					REG_LOOP_MODE: mode_q     <= cfg.data[MODE_W-1:0];
					default:       mode_q     <= mode_q;
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		now_q <= now_d;
		d_q   <= d_d;
		e_q   <= e_d;
		r_q   <= r_d;
		q_q   <= q_d;
		if (load_out) begin
			case (kind_q)
				RK_FINISHED: begin
					out_running_q <= 1'b0;
					out_pvalid_q  <= 1'b1;
					out_prog_q    <= PROG_W'(1) << FRAC_BITS;
				end
				RK_PROGRESS: begin
					out_running_q <= 1'b1;
					out_pvalid_q  <= 1'b1;
					out_prog_q    <= PROG_W'(q_q);
				end
				default: begin
					out_running_q <= 1'b1;
					out_pvalid_q  <= 1'b0;
					out_prog_q    <= '0;
				end
			endcase
		end
	end

	assign result.valid          = out_valid_q;
	assign result.running        = out_running_q;
	assign result.progress_valid = out_pvalid_q;
	assign result.progress       = out_prog_q;

	a_rewind_clears: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && item.op == OP_REWIND |=> start_q == '0)
		else $error("start stamp not cleared by rewind");

	a_mod_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD |-> r_q < d_ext)
		else $error("modulo remainder not below duration");

	a_frac_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FRAC && !frac_first |-> r_q < d_ext)
		else $error("fraction remainder not below duration");

	a_prog_max: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && kind_q == RK_PROGRESS |-> q_q <= (QW'(1) << FRAC_BITS))
		else $error("progress above one");

endmodule
